// File: design/segment_plane_intersect_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment/plane intersection block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PLANE_INTERSECT_ASSERT_SVH
`define SEGMENT_PLANE_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define SPI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPI_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPI_ASSERT(lbl, clk, rst, prop, msg)
`define SPI_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: design/spi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/plane intersection package
// Shared widths, register indexes and payload types.
// ----------------------------------------------------------------------------
package spi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   // Four terms of at most PROD_W bits each, kept exact.
   localparam int DIST_W        = PROD_W + 3;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_B = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_C = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_D = 2'd3;

   typedef logic signed [DATA_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type src;
      point_type dst;
   } seg_type;

endpackage

// File: design/spi_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment request channel
// Valid/ready channel carrying the two end points of one segment.
// ----------------------------------------------------------------------------
interface spi_req_if;
   logic              valid;
   logic              ready;
   spi_pkg::coord_type src_x;
   spi_pkg::coord_type src_y;
   spi_pkg::coord_type src_z;
   spi_pkg::coord_type dst_x;
   spi_pkg::coord_type dst_y;
   spi_pkg::coord_type dst_z;

   modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
   modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

// File: design/spi_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intersection response channel
// Valid/ready channel carrying the hit flag and the crossing point.
// ----------------------------------------------------------------------------
interface spi_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   spi_pkg::coord_type hit_x;
   spi_pkg::coord_type hit_y;
   spi_pkg::coord_type hit_z;

   modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
   modport sink   (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

// File: design/segment_plane_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/plane intersection
// Tests one segment per request against a programmed plane and returns the
// crossing point.
// ----------------------------------------------------------------------------
// The block accepts one segment every clock cycle while the response side
// is not stalled, and returns one response per request, in order. The
// pipeline depth is set by the restoring divider for t, which resolves one
// quotient bit per pipeline stage; the plane distances take three stages
// beforehand, the hit test one, and the interpolation two afterwards. A
// stall on the response side holds the whole pipeline until the response is
// taken. Plane terms must be written by the user through the csr port only
// while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "segment_plane_intersect_assert.svh"

module segment_plane_intersect #(
   parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   spi_req_if.sink                            req_bus,
   spi_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [spi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spi_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int DATA_W  = spi_pkg::DATA_W;
   localparam int PROD_W  = spi_pkg::PROD_W;
   localparam int DIST_W  = spi_pkg::DIST_W;
   localparam int REM_W   = DIST_W + 1;
   localparam int T_W     = FRAC_BITS + 1;
   localparam int DIV_N   = FRAC_BITS + 1;
   localparam int DIFF_W  = DATA_W + 1;
   localparam int LP_W    = DIFF_W + T_W + 1;
   localparam int ST_MUL  = DIV_N + 4;
   localparam int SEG_N   = ST_MUL + 1;
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

   // ------------------------------------------------------------------
   // Plane registers
   // ------------------------------------------------------------------
   spi_pkg::coord_type plane_a_ff, plane_b_ff, plane_c_ff, plane_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff <= '0;
         plane_b_ff <= '0;
         plane_c_ff <= '0;
         plane_d_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            spi_pkg::CSR_PLANE_A: plane_a_ff <= csr_wdata;
            spi_pkg::CSR_PLANE_B: plane_b_ff <= csr_wdata;
            spi_pkg::CSR_PLANE_C: plane_c_ff <= csr_wdata;
            spi_pkg::CSR_PLANE_D: plane_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage moves when the output can take a request
   // ------------------------------------------------------------------
   logic             adv;
   logic [SEG_N-1:0] vld_ff;
   logic             rsp_valid_ff;
   spi_pkg::seg_type seg_in;
   spi_pkg::seg_type seg_ff [SEG_N];

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   assign seg_in.src.x = req_bus.src_x;
   assign seg_in.src.y = req_bus.src_y;
   assign seg_in.src.z = req_bus.src_z;
   assign seg_in.dst.x = req_bus.dst_x;
   assign seg_in.dst.y = req_bus.dst_y;
   assign seg_in.dst.z = req_bus.dst_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SEG_N-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg_ff[0] <= seg_in;
         for (int k = 1; k < SEG_N; k++) begin
            seg_ff[k] <= seg_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: products of the plane normal with both end points
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] ps_in [3];
   logic signed [PROD_W-1:0] pe_in [3];
   logic signed [PROD_W-1:0] ps_ff [3];
   logic signed [PROD_W-1:0] pe_ff [3];
   logic signed [DIST_W-1:0] dterm_in, dterm_ff;

   assign ps_in[0] = PROD_W'(plane_a_ff) * PROD_W'(req_bus.src_x);
   assign ps_in[1] = PROD_W'(plane_b_ff) * PROD_W'(req_bus.src_y);
   assign ps_in[2] = PROD_W'(plane_c_ff) * PROD_W'(req_bus.src_z);
   assign pe_in[0] = PROD_W'(plane_a_ff) * PROD_W'(req_bus.dst_x);
   assign pe_in[1] = PROD_W'(plane_b_ff) * PROD_W'(req_bus.dst_y);
   assign pe_in[2] = PROD_W'(plane_c_ff) * PROD_W'(req_bus.dst_z);
   // The offset is brought to the products' doubled fraction.
   assign dterm_in = DIST_W'(plane_d_ff) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv) begin
         ps_ff    <= ps_in;
         pe_ff    <= pe_in;
         dterm_ff <= dterm_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 1 and 2: adder tree for the two plane distances
   // ------------------------------------------------------------------
   logic signed [DIST_W-1:0] s01_in, s23_in, e01_in, e23_in;
   logic signed [DIST_W-1:0] s01_ff, s23_ff, e01_ff, e23_ff;
   logic signed [DIST_W-1:0] sd_in, ed_in, sd_ff, ed_ff;

   assign s01_in = DIST_W'(ps_ff[0]) + DIST_W'(ps_ff[1]);
   assign s23_in = DIST_W'(ps_ff[2]) + dterm_ff;
   assign e01_in = DIST_W'(pe_ff[0]) + DIST_W'(pe_ff[1]);
   assign e23_in = DIST_W'(pe_ff[2]) + dterm_ff;
   assign sd_in  = s01_ff + s23_ff;
   assign ed_in  = e01_ff + e23_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s01_ff <= s01_in;
         s23_ff <= s23_in;
         e01_ff <= e01_in;
         e23_ff <= e23_in;
         sd_ff  <= sd_in;
         ed_ff  <= ed_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: hit conditions, numerator and denominator of t
   // ------------------------------------------------------------------
   logic              ok3_in, ok3_ff;
   logic [DIST_W-1:0] num3_in, num3_ff;
   logic [DIST_W-1:0] den3_in, den3_ff;

   assign num3_in = -ed_ff;
   assign den3_in = sd_ff - ed_ff;
   assign ok3_in  = !sd_ff[DIST_W-1] && (ed_ff[DIST_W-1] || (ed_ff == '0))
                    && (den3_in != '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         ok3_ff  <= ok3_in;
         num3_ff <= num3_in;
         den3_ff <= den3_in;
      end
   end

   // ------------------------------------------------------------------
   // Restoring divider, one quotient bit per stage
   // ------------------------------------------------------------------
   logic [REM_W-1:0]  rem_ff    [DIV_N];
   logic [DIST_W-1:0] den_ff    [DIV_N];
   logic [T_W-1:0]    q_ff      [DIV_N];
   logic              div_ok_ff [DIV_N];

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [REM_W-1:0]  rem_src, den_ext, trial, rem_in;
      logic [DIST_W-1:0] den_src;
      logic [T_W-1:0]    q_src, q_in;
      logic              ok_src, ge;

      if (j == 0) begin : g_first
         assign rem_src = REM_W'(num3_ff);
         assign den_src = den3_ff;
         assign q_src   = '0;
         assign ok_src  = ok3_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1] << 1;
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign ok_src  = div_ok_ff[j-1];
      end

      assign den_ext = REM_W'(den_src);
      assign ge      = rem_src >= den_ext;
      assign trial   = rem_src - den_ext;
      assign rem_in  = ge ? trial : rem_src;
      assign q_in    = {q_src[T_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]    <= rem_in;
            den_ff[j]    <= den_src;
            q_ff[j]      <= q_in;
            div_ok_ff[j] <= ok_src;
         end
      end
   end

   // ------------------------------------------------------------------
   // Interpolation multiply: (src - dst) * t per axis
   // ------------------------------------------------------------------
   spi_pkg::coord_type      msrc [3];
   spi_pkg::coord_type      mdst [3];
   logic signed [LP_W-1:0]  lp_in [3];
   logic signed [LP_W-1:0]  lp_ff [3];
   logic signed [T_W:0]     t_s;
   logic                    mul_ok_ff;

   assign msrc[0] = seg_ff[ST_MUL-1].src.x;
   assign msrc[1] = seg_ff[ST_MUL-1].src.y;
   assign msrc[2] = seg_ff[ST_MUL-1].src.z;
   assign mdst[0] = seg_ff[ST_MUL-1].dst.x;
   assign mdst[1] = seg_ff[ST_MUL-1].dst.y;
   assign mdst[2] = seg_ff[ST_MUL-1].dst.z;
   assign t_s     = $signed({1'b0, q_ff[DIV_N-1]});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lp_in[a] = (LP_W'(msrc[a]) - LP_W'(mdst[a])) * LP_W'(t_s);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_ff     <= lp_in;
         mul_ok_ff <= div_ok_ff[DIV_N-1];
      end
   end

   // ------------------------------------------------------------------
   // Output: shift back, add the destination, saturate
   // ------------------------------------------------------------------
   function automatic spi_pkg::coord_type sat_coord(input logic signed [LP_W:0] v);
      logic [LP_W-DATA_W+1:0] top;
      spi_pkg::coord_type     r;
      top = v[LP_W:DATA_W-1];
      if ((&top) || !(|top)) begin
         r = v[DATA_W-1:0];
      end else if (v[LP_W]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   spi_pkg::coord_type     odst  [3];
   spi_pkg::coord_type     pt_in [3];
   logic signed [LP_W:0]   sum_w [3];
   logic                   rsp_hit_ff;
   spi_pkg::coord_type     rsp_x_ff, rsp_y_ff, rsp_z_ff;

   assign odst[0] = seg_ff[ST_MUL].dst.x;
   assign odst[1] = seg_ff[ST_MUL].dst.y;
   assign odst[2] = seg_ff[ST_MUL].dst.z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_w[a] = (LP_W + 1)'(lp_ff[a] >>> FRAC_BITS) + (LP_W + 1)'(odst[a]);
         pt_in[a] = mul_ok_ff ? sat_coord(sum_w[a]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[SEG_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= mul_ok_ff;
         rsp_x_ff   <= pt_in[0];
         rsp_y_ff   <= pt_in[1];
         rsp_z_ff   <= pt_in[2];
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit   = rsp_hit_ff;
   assign rsp_bus.hit_x = rsp_x_ff;
   assign rsp_bus.hit_y = rsp_y_ff;
   assign rsp_bus.hit_z = rsp_z_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // After the last divider step the remainder is below the denominator.
   `SPI_ASSERT(a_rem_below_den, clock, reset,
      (vld_ff[ST_MUL-1] && div_ok_ff[DIV_N-1]
         |-> rem_ff[DIV_N-1] < REM_W'(den_ff[DIV_N-1])),
      "divider remainder not below denominator")
   // A valid hit never has t above one.
   `SPI_ASSERT(a_t_in_range, clock, reset,
      (vld_ff[ST_MUL-1] && div_ok_ff[DIV_N-1] |-> q_ff[DIV_N-1] <= T_ONE),
      "quotient t above one")
   // A miss reports the origin.
   `SPI_ASSERT(a_miss_zero, clock, reset,
      (rsp_valid_ff && !rsp_hit_ff
         |-> (rsp_x_ff == '0) && (rsp_y_ff == '0) && (rsp_z_ff == '0)),
      "miss with nonzero point")
   `SPI_ASSERT_NORST(a_reset_empty, clock,
      (reset |=> !rsp_valid_ff && (vld_ff == '0)),
      "pipeline not empty after reset")

endmodule
